// File: sv/matrix_add_sub_multiply_defines.svh
// Assertion macros used by the checker file of this block.
`ifndef MATRIX_ADD_SUB_MULTIPLY_DEFINES_SVH
`define MATRIX_ADD_SUB_MULTIPLY_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MAS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MAS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/mas_pkg.sv
`default_nettype none

package mas_pkg;

	// Matrix geometry and element width
	localparam int MAX_DIM    = 8;
	localparam int ELEM_WIDTH = 32;
	localparam int IDX_W      = 3;
	localparam int DIM_W      = 4;
	localparam int ADDR_W     = 2 * IDX_W;
	localparam int DEPTH      = MAX_DIM * MAX_DIM;
	localparam int OPER_W     = 2;

	// Stream and configuration port widths
	localparam int OP_W       = 2;
	localparam int S_DATA_W   = 40;
	localparam int M_DATA_W   = 40;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 4;

	// Item kinds carried on s_tuser
	localparam logic [OP_W-1:0] OP_WRITE_A = 2'd0;
	localparam logic [OP_W-1:0] OP_WRITE_B = 2'd1;
	localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

	// Operation register codes
	localparam logic [OPER_W-1:0] OPER_ADD = 2'd0;
	localparam logic [OPER_W-1:0] OPER_SUB = 2'd1;
	localparam logic [OPER_W-1:0] OPER_MUL = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_A    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS_B    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OPERATION = 3'd4;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_OP,
		ST_ACC,
		ST_EMIT
	} st_t;

	// Control of the shared arithmetic unit
	typedef struct packed {
		logic              op_en;
		logic              acc_en;
		logic              acc_clr;
		logic [OPER_W-1:0] mode;
	} mac_ctl_t;

endpackage

`default_nettype wire

// File: sv/mas_mac.sv
`default_nettype none

// Shared add / subtract / multiply-accumulate unit, two registered stages.
module mas_mac
	import mas_pkg::*;
(
	input  wire logic                  clk,
	input  wire mac_ctl_t              ctl,
	input  wire logic [ELEM_WIDTH-1:0] a,
	input  wire logic [ELEM_WIDTH-1:0] b,
	output logic      [ELEM_WIDTH-1:0] acc
);

	logic [ELEM_WIDTH-1:0]   op_res;
	logic [ELEM_WIDTH-1:0]   res_s1;
	logic [ELEM_WIDTH-1:0]   acc_q;

	// Select the element operation; keep the low half of the product, which wraps
	always_comb begin
		case (ctl.mode)
			OPER_SUB: op_res = a - b;
			OPER_MUL: op_res = a * b;
			default:  op_res = a + b;
		endcase
	end

	// Register the operation result
	always_ff @(posedge clk) begin
		if (ctl.op_en) begin
			res_s1 <= op_res;
		end
	end

	// Accumulate, restarting on the first term of an element
	always_ff @(posedge clk) begin
		if (ctl.acc_en) begin
			if (ctl.acc_clr) begin
				acc_q <= res_s1;
			end else begin
				acc_q <= acc_q + res_s1;
			end
		end
	end

	assign acc = acc_q;

endmodule

`default_nettype wire

// File: sv/matrix_add_sub_multiply.sv
`default_nettype none

// Integer matrix engine. Items with s_tuser OP_WRITE_A / OP_WRITE_B store
// one 32-bit element of A or B at (row, col). An OP_COMPUTE item emits
// the configured A+B, A-B or A*B (sizes from the rows/cols registers) in
// row-major order, one transfer per element with m_tlast on the final one;
// unsuitable sizes or operation give a single transfer with m_tuser
// (dimension error) set and zero data. Every element passes through one
// shared multiply-accumulate unit fed from registered store reads: each
// term goes through the read, operate and accumulate states (one term for
// add/subtract, cols_a terms for multiply) and each element then through
// the emit state, where m_tready stalls hold it. s_tready is low for the
// whole compute. Store entries read before being written return garbage.
module matrix_add_sub_multiply
	import mas_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration write port
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	// input stream
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [S_DATA_W-1:0]   s_tdata,   // row[2:0], col[5:3], value[37:6], zero
	input  wire logic [OP_W-1:0]       s_tuser,   // op[1:0]
	// result stream
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic      [M_DATA_W-1:0]   m_tdata,   // result_value[31:0], result_row[34:32],
	                                              // result_col[37:35], zero
	output logic                       m_tlast,
	output logic                       m_tuser    // dim_error
);

	// Configuration registers
	logic [DIM_W-1:0]  rows_a_q, cols_a_q, rows_b_q, cols_b_q;
	logic [OPER_W-1:0] operation_q;

	// Sequencer
	st_t              state_q, state_d;
	logic [IDX_W-1:0] i_q, j_q, k_q;
	logic             err_q;
	mac_ctl_t         mac_ctl;
	logic             start, k_inc, elem_adv, out_load;

	// Stores
	logic [ELEM_WIDTH-1:0] mem_a [DEPTH];
	logic [ELEM_WIDTH-1:0] mem_b [DEPTH];
	logic [ELEM_WIDTH-1:0] rd_a_q, rd_b_q;
	logic [ADDR_W-1:0]     waddr, raddr_a, raddr_b;

	// Result register
	logic                  out_valid_q;
	logic [ELEM_WIDTH-1:0] out_value_q;
	logic [IDX_W-1:0]      out_row_q, out_col_q;
	logic                  out_last_q, out_err_q;

	logic [IDX_W-1:0]      in_row, in_col;
	logic [ELEM_WIDTH-1:0] in_value;
	logic                  in_fire, is_mul, dims_ok, out_free;
	logic                  k_end, j_end, i_end;
	logic [DIM_W-1:0]      n_cols;
	logic [ELEM_WIDTH-1:0] acc;

	assign in_row   = s_tdata[2:0];
	assign in_col   = s_tdata[5:3];
	assign in_value = s_tdata[37:6];
	assign in_fire  = s_tvalid && s_tready;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q    <= DIM_W'(1);
			cols_a_q    <= DIM_W'(1);
			rows_b_q    <= DIM_W'(1);
			cols_b_q    <= DIM_W'(1);
			operation_q <= OPER_ADD;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROWS_A:    rows_a_q    <= cfg_wdata;
				REG_COLS_A:    cols_a_q    <= cfg_wdata;
				REG_ROWS_B:    rows_b_q    <= cfg_wdata;
				REG_COLS_B:    cols_b_q    <= cfg_wdata;
				REG_OPERATION: operation_q <= cfg_wdata[OPER_W-1:0];
				default:       ;
			endcase
		end
	end

	// Check sizes against the operation
	always_comb begin
		is_mul  = (operation_q == OPER_MUL);
		dims_ok = (rows_a_q != '0) && (rows_a_q <= DIM_W'(MAX_DIM)) &&
			(cols_a_q != '0) && (cols_a_q <= DIM_W'(MAX_DIM)) &&
			(rows_b_q != '0) && (rows_b_q <= DIM_W'(MAX_DIM)) &&
			(cols_b_q != '0) && (cols_b_q <= DIM_W'(MAX_DIM));
		if (operation_q == OPER_ADD || operation_q == OPER_SUB) begin
			dims_ok = dims_ok && (rows_a_q == rows_b_q) && (cols_a_q == cols_b_q);
		end else if (is_mul) begin
			dims_ok = dims_ok && (cols_a_q == rows_b_q);
		end else begin
			dims_ok = 1'b0;
		end
		n_cols = is_mul ? cols_b_q : cols_a_q;
		k_end  = !is_mul || (({1'b0, k_q} + DIM_W'(1)) == cols_a_q);
		j_end  = (({1'b0, j_q} + DIM_W'(1)) == n_cols);
		i_end  = (({1'b0, i_q} + DIM_W'(1)) == rows_a_q);
	end

	assign out_free = !out_valid_q || m_tready;

	// Next state and control
	always_comb begin
		state_d      = state_q;
		s_tready     = 1'b0;
		start        = 1'b0;
		k_inc        = 1'b0;
		elem_adv     = 1'b0;
		out_load     = 1'b0;
		mac_ctl.op_en   = 1'b0;
		mac_ctl.acc_en  = 1'b0;
		mac_ctl.acc_clr = (k_q == '0);
		mac_ctl.mode    = operation_q;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (in_fire && s_tuser == OP_COMPUTE) begin
					start   = 1'b1;
					state_d = dims_ok ? ST_READ : ST_EMIT;
				end
			end
			ST_READ: begin
				state_d = ST_OP;
			end
			ST_OP: begin
				mac_ctl.op_en = 1'b1;
				state_d       = ST_ACC;
			end
			ST_ACC: begin
				mac_ctl.acc_en = 1'b1;
				if (k_end) begin
					state_d = ST_EMIT;
				end else begin
					k_inc   = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					if (err_q || (i_end && j_end)) begin
						state_d = ST_IDLE;
					end else begin
						elem_adv = 1'b1;
						state_d  = ST_READ;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Advance state and element counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			err_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start) begin
				i_q   <= '0;
				j_q   <= '0;
				k_q   <= '0;
				err_q <= !dims_ok;
			end else if (k_inc) begin
				k_q <= k_q + IDX_W'(1);
			end else if (elem_adv) begin
				k_q <= '0;
				if (j_end) begin
					j_q <= '0;
					i_q <= i_q + IDX_W'(1);
				end else begin
					j_q <= j_q + IDX_W'(1);
				end
			end
		end
	end

	// Store addresses: A(i,k) and B(k,j) for multiply, both (i,j) otherwise
	assign waddr   = {in_row, in_col};
	assign raddr_a = {i_q, is_mul ? k_q : j_q};
	assign raddr_b = {is_mul ? k_q : i_q, j_q};

	always_ff @(posedge clk) begin
		if (in_fire && s_tuser == OP_WRITE_A) begin
			mem_a[waddr] <= in_value;
		end
		rd_a_q <= mem_a[raddr_a];
	end

	always_ff @(posedge clk) begin
		if (in_fire && s_tuser == OP_WRITE_B) begin
			mem_b[waddr] <= in_value;
		end
		rd_b_q <= mem_b[raddr_b];
	end

	mas_mac u_mac (
		.clk    (clk),
		.ctl    (mac_ctl),
		.a      (rd_a_q),
		.b      (rd_b_q),
		.acc    (acc)
	);

	// Result register valid: set on load, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_value_q <= err_q ? '0 : acc;
			out_row_q   <= err_q ? '0 : i_q;
			out_col_q   <= err_q ? '0 : j_q;
			out_last_q  <= err_q || (i_end && j_end);
			out_err_q   <= err_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_col_q, out_row_q, out_value_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_err_q;

endmodule

`default_nettype wire

// File: sv/mas_checker.sv
`default_nettype none

`include "matrix_add_sub_multiply_defines.svh"

// Port-level checks on the matrix engine.
module mas_checker
	import mas_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                s_tvalid,
	input wire logic                s_tready,
	input wire logic [OP_W-1:0]     s_tuser,
	input wire logic                m_tvalid,
	input wire logic                m_tready,
	input wire logic [M_DATA_W-1:0] m_tdata,
	input wire logic                m_tlast,
	input wire logic                m_tuser
);

	// A stalled result holds its payload
	`MAS_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "result changed while stalled")

	// An error result is a single, zero transfer
	`MAS_ASSERT_NOW(a_err_single, clk, arst_n, m_tvalid && m_tuser, m_tlast && (m_tdata == '0), "error result not single or not zero")

	// A compute transfer closes the input side
	`MAS_ASSERT_NEXT(a_compute_busy, clk, arst_n, s_tvalid && s_tready && (s_tuser == OP_COMPUTE), !s_tready, "input ready right after compute transfer")

	// The input side stays closed until the final result is loaded
	`MAS_ASSERT_NOW(a_busy_until_last, clk, arst_n, m_tvalid && !m_tlast, !s_tready, "input ready before final result")

endmodule

bind matrix_add_sub_multiply mas_checker u_mas_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

`default_nettype wire
